@@ hdl/wsdf_pkg.sv @@
// Shared result type, codes and header-length helper function of the frame deframer.
package wsdf_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_RSV        = 3'd0;
   localparam logic [2:0] ERR_OPCODE     = 3'd1;
   localparam logic [2:0] ERR_CTL_NOFIN  = 3'd2;
   localparam logic [2:0] ERR_CTL_LONG   = 3'd3;
   localparam logic [2:0] ERR_CTL_RSV1   = 3'd4;
   localparam logic [2:0] ERR_LEN_MSB    = 3'd5;
   localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [6:0] LEN_CODE_16  = 7'd126;
   localparam logic [6:0] LEN_CODE_64  = 7'd127;
   localparam logic [6:0] CTL_LEN_MAX  = 7'd125;
   localparam logic [3:0] OPC_DATA_MAX = 4'h2;
   localparam logic [3:0] OPC_CTL_MAX  = 4'hA;

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin;
      logic        rsv1;
      logic [3:0]  opcode;
      logic        masked;
      logic [62:0] payload_length;
      logic [3:0]  header_length;
      logic [31:0] frame_key;
      logic [7:0]  payload_data;
      logic        last;
      logic [2:0]  error_code;
   } result_type;

   // Header length in bytes for a given length code and mask bit.
   function automatic logic [3:0] hdr_len(input logic [6:0] code, input logic mask);
      logic [3:0] n;
      n = 4'd2;
      if (code == LEN_CODE_16) begin
         n = n + 4'd2;
      end else if (code == LEN_CODE_64) begin
         n = n + 4'd8;
      end
      if (mask) begin
         n = n + 4'd4;
      end
      return n;
   endfunction

endpackage

@@ hdl/wsdf_parser.sv @@
// Frame header parser and payload unmasker: parse state and one-byte step logic.
module wsdf_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   step_op,
   input  logic [7:0]             step_byte,
   output logic                   emit,
   output wsdf_pkg::result_type   res
);

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [6:0]  code_ff, code_in;
   logic        mask_ff, mask_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  pend_ff, pend_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  kidx_ff, kidx_in;
   logic [62:0] rem_ff, rem_in;
   logic        halted_ff, halted_in;

   logic        err_req;
   logic [2:0]  err_code;
   logic        fin_req;
   logic [63:0] fin_acc;
   logic [31:0] fin_key;
   logic        pay_req;
   logic [7:0]  pay_data;
   logic        pay_last;
   logic [3:0]  fin_hl;
   logic [63:0] fin_sum;
   logic        too_large;
   logic [3:0]  opc;
   logic        ctl;
   logic [63:0] acc_shift;
   logic [31:0] key_shift;
   logic [3:0]  pend_dec;
   logic [62:0] rem_dec;
   logic [7:0]  key_byte;

   assign opc       = hdr_ff[3:0];
   assign ctl       = hdr_ff[3];
   assign acc_shift = {acc_ff[55:0], step_byte};
   assign key_shift = {key_ff[23:0], step_byte};
   assign pend_dec  = pend_ff - 4'd1;
   assign rem_dec   = rem_ff - 63'd1;

   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      code_in   = code_ff;
      mask_in   = mask_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      rem_in    = rem_ff;
      halted_in = halted_ff;
      err_req   = 1'b0;
      err_code  = wsdf_pkg::ERR_RSV;
      fin_req   = 1'b0;
      fin_acc   = acc_ff;
      fin_key   = key_ff;
      pay_req   = 1'b0;
      pay_data  = 8'd0;
      pay_last  = 1'b0;
      if (step_op == wsdf_pkg::OP_RESTART) begin
         phase_in  = PH_FIRST;
         hdr_in    = 8'd0;
         code_in   = 7'd0;
         mask_in   = 1'b0;
         acc_in    = 64'd0;
         pend_in   = 4'd0;
         key_in    = 32'd0;
         kidx_in   = 2'd0;
         rem_in    = 63'd0;
         halted_in = 1'b0;
      end else if (!halted_ff) begin
         case (phase_ff)
            PH_FIRST: begin
               hdr_in   = step_byte;
               mask_in  = 1'b0;
               code_in  = 7'd0;
               acc_in   = 64'd0;
               key_in   = 32'd0;
               kidx_in  = 2'd0;
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               mask_in = step_byte[7];
               code_in = step_byte[6:0];
               if (hdr_ff[5:4] != 2'b00) begin
                  err_req  = 1'b1;
                  err_code = wsdf_pkg::ERR_RSV;
               end else if (!(opc <= wsdf_pkg::OPC_DATA_MAX ||
                              (ctl && opc <= wsdf_pkg::OPC_CTL_MAX))) begin
                  err_req  = 1'b1;
                  err_code = wsdf_pkg::ERR_OPCODE;
               end else if (ctl && !hdr_ff[7]) begin
                  err_req  = 1'b1;
                  err_code = wsdf_pkg::ERR_CTL_NOFIN;
               end else if (ctl && step_byte[6:0] > wsdf_pkg::CTL_LEN_MAX) begin
                  err_req  = 1'b1;
                  err_code = wsdf_pkg::ERR_CTL_LONG;
               end else if (ctl && hdr_ff[6]) begin
                  err_req  = 1'b1;
                  err_code = wsdf_pkg::ERR_CTL_RSV1;
               end else if (step_byte[6:0] < wsdf_pkg::LEN_CODE_16) begin
                  acc_in = {57'd0, step_byte[6:0]};
                  if (step_byte[7]) begin
                     pend_in  = 4'd4;
                     key_in   = 32'd0;
                     phase_in = PH_KEY;
                  end else begin
                     fin_req = 1'b1;
                     fin_acc = {57'd0, step_byte[6:0]};
                  end
               end else begin
                  acc_in   = 64'd0;
                  pend_in  = (step_byte[6:0] == wsdf_pkg::LEN_CODE_16) ? 4'd2 : 4'd8;
                  phase_in = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               acc_in  = acc_shift;
               pend_in = pend_dec;
               if (pend_dec == 4'd0) begin
                  if (code_ff == wsdf_pkg::LEN_CODE_64 && acc_shift[63]) begin
                     err_req  = 1'b1;
                     err_code = wsdf_pkg::ERR_LEN_MSB;
                  end else if (mask_ff) begin
                     pend_in  = 4'd4;
                     key_in   = 32'd0;
                     phase_in = PH_KEY;
                  end else begin
                     fin_req = 1'b1;
                     fin_acc = acc_shift;
                  end
               end
            end
            PH_KEY: begin
               key_in  = key_shift;
               pend_in = pend_dec;
               if (pend_dec == 4'd0) begin
                  fin_req = 1'b1;
                  fin_key = key_shift;
               end
            end
            PH_PAYLOAD: begin
               kidx_in  = kidx_ff + 2'd1;
               rem_in   = rem_dec;
               pay_req  = 1'b1;
               pay_data = step_byte ^ key_byte;
               pay_last = (rem_dec == 63'd0);
               if (rem_dec == 63'd0) begin
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   // The too-large check is a carry out of the 63-bit length plus header length.
   assign fin_hl    = wsdf_pkg::hdr_len(code_in, mask_in);
   assign fin_sum   = {1'b0, fin_acc[62:0]} + {60'd0, fin_hl};
   assign too_large = fin_sum[63] | fin_acc[63];

   logic        hdr_ok;
   logic        err_any;
   logic [2:0]  err_any_code;
   logic [2:0]  phase_fin;
   logic [1:0]  kidx_fin;
   logic [62:0] rem_fin;
   logic        halted_fin;

   assign hdr_ok       = fin_req && !too_large;
   assign err_any      = err_req || (fin_req && too_large);
   assign err_any_code = err_req ? err_code : wsdf_pkg::ERR_TOO_LARGE;

   always_comb begin
      phase_fin  = phase_in;
      kidx_fin   = kidx_in;
      rem_fin    = rem_in;
      halted_fin = halted_in;
      if (err_any) begin
         halted_fin = 1'b1;
      end else if (hdr_ok) begin
         if (fin_acc == 64'd0) begin
            phase_fin = PH_FIRST;
         end else begin
            rem_fin   = fin_acc[62:0];
            kidx_fin  = 2'd0;
            phase_fin = PH_PAYLOAD;
         end
      end
   end

   always_comb begin
      res        = '0;
      res.fin    = hdr_in[7];
      res.rsv1   = hdr_in[6];
      res.opcode = hdr_in[3:0];
      res.masked = mask_in;
      if (err_any) begin
         res.kind       = wsdf_pkg::KIND_ERROR;
         res.error_code = err_any_code;
      end else if (hdr_ok) begin
         res.kind           = wsdf_pkg::KIND_HEADER;
         res.payload_length = fin_acc[62:0];
         res.header_length  = fin_hl;
         res.frame_key      = fin_key;
         res.last           = (fin_acc == 64'd0);
      end else begin
         res.kind           = wsdf_pkg::KIND_PAYLOAD;
         res.payload_length = acc_ff[62:0];
         res.header_length  = wsdf_pkg::hdr_len(code_ff, mask_ff);
         res.frame_key      = key_ff;
         res.payload_data   = pay_data;
         res.last           = pay_last;
      end
   end

   assign emit = step && (err_any || hdr_ok || pay_req);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         hdr_ff    <= 8'd0;
         code_ff   <= 7'd0;
         mask_ff   <= 1'b0;
         acc_ff    <= 64'd0;
         pend_ff   <= 4'd0;
         key_ff    <= 32'd0;
         kidx_ff   <= 2'd0;
         rem_ff    <= 63'd0;
         halted_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_fin;
         hdr_ff    <= hdr_in;
         code_ff   <= code_in;
         mask_ff   <= mask_in;
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_fin;
         rem_ff    <= rem_fin;
         halted_ff <= halted_fin;
      end
   end

endmodule

@@ hdl/wsdf_out_buf.sv @@
// Two-entry result buffer between the parser and the result channel.
module wsdf_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsdf_pkg::result_type   push_data,
   input  logic                   pop_stall,
   output logic                   full,
   output logic                   out_valid,
   output wsdf_pkg::result_type   out_data
);

   wsdf_pkg::result_type ent_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign pop       = out_valid && !pop_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

@@ hdl/websocket_deframer_unmask_top.sv @@
// Top level of the frame deframer: input register, parser and result buffer.
//
// Takes one byte of a framed stream per beat and returns at most one result per
// beat: a header result when a frame header is complete, one unmasked payload
// byte per payload beat, or an error result that halts the parser until a
// restart beat. A new input beat is taken every cycle while the result side
// keeps up; a result passes through the input register and then an entry of
// the two-entry output buffer before it is on the result ports. When the
// output buffer is full and the input register holds a beat, that beat waits
// and req_stall rises.
module websocket_deframer_unmask_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_op,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_kind,
   output logic         rsp_fin,
   output logic         rsp_rsv1,
   output logic [3:0]   rsp_opcode,
   output logic         rsp_masked,
   output logic [62:0]  rsp_payload_length,
   output logic [3:0]   rsp_header_length,
   output logic [31:0]  rsp_frame_key,
   output logic [7:0]   rsp_payload_data,
   output logic         rsp_last,
   output logic [2:0]   rsp_error_code
);

   logic                 in_valid_ff;
   logic                 in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 buf_full;
   logic                 advance;
   logic                 emit;
   wsdf_pkg::result_type res;
   wsdf_pkg::result_type out_res;

   assign advance   = in_valid_ff && !buf_full;
   assign req_stall = in_valid_ff && buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
   end

   wsdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .step_op   (in_op_ff),
      .step_byte (in_byte_ff),
      .emit      (emit),
      .res       (res)
   );

   wsdf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (res),
      .pop_stall (rsp_stall),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (out_res)
   );

   assign rsp_kind           = out_res.kind;
   assign rsp_fin            = out_res.fin;
   assign rsp_rsv1           = out_res.rsv1;
   assign rsp_opcode         = out_res.opcode;
   assign rsp_masked         = out_res.masked;
   assign rsp_payload_length = out_res.payload_length;
   assign rsp_header_length  = out_res.header_length;
   assign rsp_frame_key      = out_res.frame_key;
   assign rsp_payload_data   = out_res.payload_data;
   assign rsp_last           = out_res.last;
   assign rsp_error_code     = out_res.error_code;

endmodule

@@ hdl/wsdf_checker.sv @@
// Port-level checker of the frame deframer and its bind to the top level.
module wsdf_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [1:0]   rsp_kind,
   input logic [62:0]  rsp_payload_length,
   input logic [3:0]   rsp_header_length,
   input logic [7:0]   rsp_payload_data,
   input logic         rsp_last,
   input logic [2:0]   rsp_error_code
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result beat dropped while stalled.");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_kind) && $stable(rsp_payload_data)
         && $stable(rsp_last))
      else $error("Stalled result beat changed.");

   a_header_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wsdf_pkg::KIND_HEADER |->
         rsp_last == (rsp_payload_length == 63'd0) && rsp_header_length >= 4'd2
         && rsp_error_code == wsdf_pkg::ERR_RSV)
      else $error("Header result fields are inconsistent.");

   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wsdf_pkg::KIND_ERROR |->
         !rsp_last && rsp_payload_length == 63'd0 && rsp_header_length == 4'd0
         && rsp_payload_data == 8'd0)
      else $error("Error result carries frame fields.");

endmodule

bind websocket_deframer_unmask_top wsdf_checker u_wsdf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_payload_length (rsp_payload_length),
   .rsp_header_length  (rsp_header_length),
   .rsp_payload_data   (rsp_payload_data),
   .rsp_last           (rsp_last),
   .rsp_error_code     (rsp_error_code)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the frame deframer with its own parser model and checker.
module testbench;

   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [2:0]  NO_ERROR    = 3'd0;
   localparam logic [3:0]  OPC_CONT    = 4'h0;
   localparam logic [3:0]  OPC_TEXT    = 4'h1;
   localparam logic [3:0]  OPC_BINARY  = 4'h2;
   localparam logic [3:0]  OPC_CLOSE   = 4'h8;
   localparam logic [3:0]  OPC_PING    = 4'h9;
   localparam logic [3:0]  OPC_PONG    = 4'hA;
   localparam logic [63:0] LEN63_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [2:0]  PH_FIRST    = 3'd0;
   localparam logic [2:0]  PH_SECOND   = 3'd1;
   localparam logic [2:0]  PH_EXTLEN   = 3'd2;
   localparam logic [2:0]  PH_KEY      = 3'd3;
   localparam logic [2:0]  PH_PAYLOAD  = 3'd4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = wsdf_pkg::OP_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic        rsp_fin;
   logic        rsp_rsv1;
   logic [3:0]  rsp_opcode;
   logic        rsp_masked;
   logic [62:0] rsp_payload_length;
   logic [3:0]  rsp_header_length;
   logic [31:0] rsp_frame_key;
   logic [7:0]  rsp_payload_data;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;

   wsdf_pkg::result_type pending_results[$];
   int           mismatches = 0;
   int           cycles = 0;
   int           beats_parsed = 0;
   bit           steady = 1'b0;

   logic [2:0]   phase = PH_FIRST;
   logic [7:0]   hdr_byte = 8'h00;
   logic [6:0]   len_code = 7'd0;
   logic         key_on = 1'b0;
   logic [63:0]  len_acc = 64'd0;
   logic [3:0]   pending = 4'd0;
   logic [31:0]  key = 32'd0;
   logic [1:0]   key_pos = 2'd0;
   logic [62:0]  remaining = 63'd0;
   logic         halted = 1'b0;

   websocket_deframer_unmask_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_fin(rsp_fin),
      .rsp_rsv1(rsp_rsv1),
      .rsp_opcode(rsp_opcode),
      .rsp_masked(rsp_masked),
      .rsp_payload_length(rsp_payload_length),
      .rsp_header_length(rsp_header_length),
      .rsp_frame_key(rsp_frame_key),
      .rsp_payload_data(rsp_payload_data),
      .rsp_last(rsp_last),
      .rsp_error_code(rsp_error_code)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 8);
   end

   function automatic logic [3:0] header_size();
      logic [3:0] n;
      n = 4'd2;
      if (len_code == wsdf_pkg::LEN_CODE_16) begin
         n = n + 4'd2;
      end else if (len_code == wsdf_pkg::LEN_CODE_64) begin
         n = n + 4'd8;
      end
      if (key_on) begin
         n = n + 4'd4;
      end
      return n;
   endfunction

   function automatic wsdf_pkg::result_type pack_result(input logic [1:0] kind,
         input logic [62:0] plen, input logic [3:0] hlen, input logic [31:0] mkey,
         input logic [7:0] data, input logic last, input logic [2:0] err);
      wsdf_pkg::result_type r;
      r.kind = kind;
      r.fin = hdr_byte[7];
      r.rsv1 = hdr_byte[6];
      r.opcode = hdr_byte[3:0];
      r.masked = key_on;
      r.payload_length = plen;
      r.header_length = hlen;
      r.frame_key = mkey;
      r.payload_data = data;
      r.last = last;
      r.error_code = err;
      return r;
   endfunction

   function automatic void reset_parser_model();
      phase = PH_FIRST;
      hdr_byte = 8'h00;
      len_code = 7'd0;
      key_on = 1'b0;
      len_acc = 64'd0;
      pending = 4'd0;
      key = 32'd0;
      key_pos = 2'd0;
      remaining = 63'd0;
      halted = 1'b0;
   endfunction

   function automatic void raise_error(input logic [2:0] err);
      halted = 1'b1;
      pending_results.push_back(pack_result(wsdf_pkg::KIND_ERROR, 63'd0, 4'd0, 32'd0, 8'h00,
                                            1'b0, err));
   endfunction

   function automatic void complete_header();
      logic [3:0] hl;
      hl = header_size();
      if (len_acc > LEN63_LIMIT - {60'd0, hl}) begin
         raise_error(wsdf_pkg::ERR_TOO_LARGE);
         return;
      end
      pending_results.push_back(pack_result(wsdf_pkg::KIND_HEADER, len_acc[62:0], hl, key,
                                            8'h00, len_acc == 64'd0, NO_ERROR));
      if (len_acc == 64'd0) begin
         phase = PH_FIRST;
      end else begin
         remaining = len_acc[62:0];
         key_pos = 2'd0;
         phase = PH_PAYLOAD;
      end
   endfunction

   function automatic void length_done();
      if (key_on) begin
         pending = 4'd4;
         key = 32'd0;
         phase = PH_KEY;
      end else begin
         complete_header();
      end
   endfunction

   function automatic void deframe_byte(input logic op, input logic [7:0] b);
      logic       ctl;
      logic [7:0] kb;
      if (op == wsdf_pkg::OP_RESTART) begin
         beats_parsed++;
         reset_parser_model();
         return;
      end
      if (halted) begin
         return;
      end
      beats_parsed++;
      case (phase)
         PH_FIRST: begin
            hdr_byte = b;
            key_on = 1'b0;
            len_code = 7'd0;
            len_acc = 64'd0;
            key = 32'd0;
            key_pos = 2'd0;
            phase = PH_SECOND;
         end
         PH_SECOND: begin
            ctl = hdr_byte[3];
            key_on = b[7];
            len_code = b[6:0];
            if (hdr_byte[5:4] != 2'b00) begin
               raise_error(wsdf_pkg::ERR_RSV);
            end else if (!(hdr_byte[3:0] <= wsdf_pkg::OPC_DATA_MAX ||
                           (ctl && hdr_byte[3:0] <= wsdf_pkg::OPC_CTL_MAX))) begin
               raise_error(wsdf_pkg::ERR_OPCODE);
            end else if (ctl && !hdr_byte[7]) begin
               raise_error(wsdf_pkg::ERR_CTL_NOFIN);
            end else if (ctl && len_code > wsdf_pkg::CTL_LEN_MAX) begin
               raise_error(wsdf_pkg::ERR_CTL_LONG);
            end else if (ctl && hdr_byte[6]) begin
               raise_error(wsdf_pkg::ERR_CTL_RSV1);
            end else if (len_code < wsdf_pkg::LEN_CODE_16) begin
               len_acc = {57'd0, len_code};
               length_done();
            end else begin
               len_acc = 64'd0;
               pending = (len_code == wsdf_pkg::LEN_CODE_16) ? 4'd2 : 4'd8;
               phase = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            len_acc = {len_acc[55:0], b};
            pending = pending - 4'd1;
            if (pending == 4'd0) begin
               if (len_code == wsdf_pkg::LEN_CODE_64 && len_acc[63]) begin
                  raise_error(wsdf_pkg::ERR_LEN_MSB);
               end else begin
                  length_done();
               end
            end
         end
         PH_KEY: begin
            key = {key[23:0], b};
            pending = pending - 4'd1;
            if (pending == 4'd0) begin
               complete_header();
            end
         end
         PH_PAYLOAD: begin
            kb = key[8 * (3 - key_pos) +: 8];
            key_pos = key_pos + 2'd1;
            remaining = remaining - 63'd1;
            pending_results.push_back(pack_result(wsdf_pkg::KIND_PAYLOAD, len_acc[62:0],
                                                  header_size(), key, b ^ kb,
                                                  remaining == 63'd0, NO_ERROR));
            if (remaining == 63'd0) begin
               phase = PH_FIRST;
            end
         end
         default: begin
            phase = PH_FIRST;
         end
      endcase
   endfunction

   function automatic string describe(input wsdf_pkg::result_type r);
      return {$sformatf("kind=%0d fin=%0d rsv1=%0d opc=%h mask=%0d plen=%h ",
                        r.kind, r.fin, r.rsv1, r.opcode, r.masked, r.payload_length),
              $sformatf("hlen=%0d key=%h data=%h last=%0d err=%0d", r.header_length,
                        r.frame_key, r.payload_data, r.last, r.error_code)};
   endfunction

   function automatic void flag_mismatch(input string what,
         input wsdf_pkg::result_type want, input wsdf_pkg::result_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $time, what);
         $display("   expected %s", describe(want));
         $display("   actual   %s", describe(seen));
      end
   endfunction

   always @(posedge clock) begin : check_results
      wsdf_pkg::result_type seen;
      wsdf_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_kind, rsp_fin, rsp_rsv1, rsp_opcode, rsp_masked, rsp_payload_length,
                 rsp_header_length, rsp_frame_key, rsp_payload_data, rsp_last, rsp_error_code};
         if (pending_results.size() == 0) begin
            flag_mismatch("result beat with no expectation", '0, seen);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               flag_mismatch("result beat mismatch", want, seen);
            end
         end
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] b);
      if (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      deframe_byte(op, b);
   endtask

   task automatic send_word(input logic [63:0] w, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         send_beat(wsdf_pkg::OP_BYTE, w[8 * i +: 8]);
      end
   endtask

   task automatic restart_parser();
      send_beat(wsdf_pkg::OP_RESTART, 8'($urandom));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_frame(input logic [7:0] first, input logic masked,
         input int unsigned form, input logic [63:0] len, input int unsigned body);
      send_beat(wsdf_pkg::OP_BYTE, first);
      if (form == 0) begin
         send_beat(wsdf_pkg::OP_BYTE, {masked, len[6:0]});
      end else if (form == 1) begin
         send_beat(wsdf_pkg::OP_BYTE, {masked, wsdf_pkg::LEN_CODE_16});
         send_word(len, 2);
      end else begin
         send_beat(wsdf_pkg::OP_BYTE, {masked, wsdf_pkg::LEN_CODE_64});
         send_word(len, 8);
      end
      if (masked) begin
         send_word(64'($urandom), 4);
      end
      repeat (body) send_beat(wsdf_pkg::OP_BYTE, 8'($urandom));
   endtask

   task automatic random_frame();
      logic [3:0]  opc;
      logic        fin;
      logic        rsv1;
      logic        masked;
      int unsigned form;
      int unsigned len;
      case ($urandom_range(5))
         0: opc = OPC_CONT;
         1: opc = OPC_TEXT;
         2: opc = OPC_BINARY;
         3: opc = OPC_CLOSE;
         4: opc = OPC_PING;
         default: opc = OPC_PONG;
      endcase
      fin = 1'($urandom_range(1));
      rsv1 = 1'($urandom_range(1));
      masked = 1'($urandom_range(1));
      form = 0;
      len = ($urandom_range(19) == 0) ? $urandom_range(125) : $urandom_range(8);
      if (opc[3]) begin
         fin = 1'b1;
         rsv1 = 1'b0;
      end else if ($urandom_range(9) < 3) begin
         form = $urandom_range(1, 2);
         len = ($urandom_range(9) == 0) ? $urandom_range(126, 300) : $urandom_range(12);
      end
      send_frame({fin, rsv1, 2'b00, opc}, masked, form, 64'(len), len);
   endtask

   task automatic broken_frame();
      int unsigned form;
      logic [63:0] len;
      form = $urandom_range(1, 2);
      len = (form == 1) ? 64'($urandom_range(65535)) : {$urandom, $urandom};
      send_frame({1'($urandom_range(1)), 1'($urandom_range(1)), 2'b00, OPC_BINARY},
                 1'($urandom_range(1)), form, len, $urandom_range(4));
      restart_parser();
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(2, 6)) send_beat(wsdf_pkg::OP_BYTE, 8'($urandom));
      restart_parser();
   endtask

   task automatic test_valid_frames();
      send_word(64'h8100, 2);
      send_word(64'h8283, 2);
      send_word(64'hA1B2_C3D4, 4);
      send_word(64'h00FF5A, 3);
      send_word(64'h4001FF, 3);
      send_word(64'h8880_0102_0304, 6);
      send_word(64'h827E_0001_C3, 5);
   endtask

   task automatic test_header_checks();
      send_word(64'hB3FE, 2);
      send_word(64'h8100, 2);
      restart_parser();
      send_word(64'h8300, 2);
      restart_parser();
      send_word(64'h09FE, 2);
      restart_parser();
      send_word(64'h89FE, 2);
      restart_parser();
      send_word(64'hC8FE, 2);
      restart_parser();
      send_word(64'hC900, 2);
      restart_parser();
   endtask

   task automatic test_length_limits();
      send_word(64'h827F, 2);
      send_word(64'h8000_0000_0000_0000, 8);
      restart_parser();
      send_word(64'h82FF, 2);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 8);
      send_word(64'h0102_0304, 4);
      restart_parser();
      send_word(64'hC27F, 2);
      send_word(64'h7FFF_FFFF_FFFF_FFF5, 8);
      send_word(64'h55AA, 2);
      restart_parser();
      send_word(64'h82FF, 2);
      send_word(64'h7FFF_FFFF_FFFF_FFF1, 8);
      send_word(64'hFF_FFFF_FF00, 5);
      send_word(64'h827E, 2);
      send_word(64'hFFFF, 2);
      send_beat(wsdf_pkg::OP_BYTE, 8'h7E);
      restart_parser();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (10) random_frame();
      steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int n);
      int start;
      int pick;
      start = beats_parsed;
      while (beats_parsed < start + n) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            random_frame();
         end else if (pick < 85) begin
            broken_frame();
         end else if (pick < 95) begin
            noise_burst();
         end else begin
            restart_parser();
         end
         if ($urandom_range(29) == 0) begin
            wait_for_results();
         end
      end
   endtask

   initial begin
      reset_parser_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_valid_frames();
      test_header_checks();
      test_length_limits();
      test_back_to_back();
      test_random_traffic(150);
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
